### rtl/tsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

  localparam int unsigned MaxElectrodes  = 16;
  localparam int unsigned CountBits      = 16;
  localparam int unsigned CountFieldBits = 16;
  localparam int unsigned ThrBits        = 16;
  localparam int unsigned ScaleBits      = 13;
  localparam int unsigned ElecCntBits    = 5;
  localparam int unsigned ChanBits       = 4;
  localparam int unsigned CfgDataBits    = 16;
  localparam int unsigned CfgIdxBits     = 2;
  localparam int unsigned PtrBits        = $clog2(MaxElectrodes);
  localparam int unsigned SumBits        = CountBits + 1;
  localparam int unsigned StepBits       = $clog2(ScaleBits);

  localparam logic CmdCal  = 1'b0;
  localparam logic CmdScan = 1'b1;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_FULL_SCALE = 2'd1,
    CFG_ELEC_COUNT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                 start;
    logic [CountBits-1:0] num;
    logic [SumBits-1:0]   den;
    logic [ScaleBits-1:0] scale;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [ScaleBits-1:0] quot;
    logic                 rem_nz;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/tsp_muldiv.sv
`timescale 1ns / 1ps
`default_nettype none

// serial num * scale / den, one multiplier bit then one quotient bit per cycle
module tsp_muldiv (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tsp_pkg::div_req_t req_i,
  output tsp_pkg::div_rsp_t      rsp_o
);
  import tsp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_MUL  = 4'b0010,
    PH_DIV  = 4'b0100,
    PH_DONE = 4'b1000
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [StepBits-1:0]  step_q, step_d;
  logic [SumBits-1:0]   acc_q, acc_d;
  logic [ScaleBits-1:0] lo_q, lo_d;
  logic [CountBits-1:0] num_q, num_d;
  logic [SumBits-1:0]   den_q, den_d;

  logic [SumBits-1:0]   mul_sum;
  logic [SumBits:0]     trial;
  logic [SumBits:0]     diff;
  logic                 ge;
  logic                 last_step;

  assign mul_sum   = {1'b0, acc_q[CountBits-1:0]} + (lo_q[0] ? {1'b0, num_q} : '0);
  assign trial     = {acc_q, lo_q[ScaleBits-1]};
  assign diff      = trial - {1'b0, den_q};
  assign ge        = trial >= {1'b0, den_q};
  assign last_step = step_q == StepBits'(ScaleBits - 1);

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    acc_d   = acc_q;
    lo_d    = lo_q;
    num_d   = num_q;
    den_d   = den_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (req_i.start) begin
          acc_d   = '0;
          lo_d    = req_i.scale;
          num_d   = req_i.num;
          den_d   = req_i.den;
          step_d  = '0;
          phase_d = PH_MUL;
        end
      end
      PH_MUL: begin
        // shift-add, product high half ends in acc, low half in lo
        acc_d  = {1'b0, mul_sum[SumBits-1:1]};
        lo_d   = {mul_sum[0], lo_q[ScaleBits-1:1]};
        step_d = step_q + StepBits'(1);
        if (last_step) begin
          step_d  = '0;
          phase_d = PH_DIV;
        end
      end
      PH_DIV: begin
        // quotient fits scale width, so the high half is already below den
        acc_d  = ge ? diff[SumBits-1:0] : trial[SumBits-1:0];
        lo_d   = {lo_q[ScaleBits-2:0], ge};
        step_d = step_q + StepBits'(1);
        if (last_step) begin
          step_d  = '0;
          phase_d = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= '0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    lo_q  <= lo_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign rsp_o.done   = phase_q == PH_DONE;
  assign rsp_o.quot   = lo_q;
  assign rsp_o.rem_nz = |acc_q;

endmodule

`default_nettype wire

### rtl/touch_slider_position_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-electrode capacitive slider front end.
// Input channel (in_valid_i / in_stall_o, cmd_i, count_i): one request per
// electrode scan. cmd_i low stores count_i as the baseline of the next
// electrode in calibration order; cmd_i high stores the clamped delta of the
// electrode under scan and advances the scan pointer.
// Output channel (out_valid_o / out_stall_i): one result per request with the
// next channel to scan, the touched flag, the position and the new delta.
// From acceptance a request passes S_EVAL, then S_DIV only when touched,
// then S_HOLD and the output register; the serial multiply/divide unit
// takes one bit per cycle, forming delta0 * full_scale, then the quotient.
// One request is in work at a time; the next is taken the cycle after its
// result enters the output register, while that result may still be
// stalled. The output register holds its result for as long as
// out_stall_i is high. Configuration writes (cfg_we_i) are registered;
// the user must make them only while idle, as the block itself does not
// enforce it. Reset clears both electrode stores and pointers and restores
// threshold 100, full scale 100 and two electrodes.
module touch_slider_position_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tsp_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [tsp_pkg::CfgDataBits-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            cmd_i,
  input  wire logic [tsp_pkg::CountFieldBits-1:0] count_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [tsp_pkg::ChanBits-1:0]         next_channel_o,
  output logic                                 touched_o,
  output logic [tsp_pkg::ScaleBits-1:0]        position_o,
  output logic [tsp_pkg::CountFieldBits-1:0]   electrode_delta_o
);
  import tsp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DIV  = 4'b0100,
    S_HOLD = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [ThrBits-1:0]     thr_q;
  logic [ScaleBits-1:0]   fs_q;
  logic [ElecCntBits-1:0] ecnt_q;

  logic [CountBits-1:0] base_q [MaxElectrodes];
  logic [CountBits-1:0] delta_q [MaxElectrodes];
  logic [PtrBits-1:0]   scan_ptr_q, cal_ptr_q;

  logic [CountBits-1:0] edelta_q, edelta_d;
  logic                 touched_q, touched_d;
  logic [ScaleBits-1:0] pos_q, pos_d;

  logic                      out_valid_q, out_valid_d;
  logic [ChanBits-1:0]       out_chan_q;
  logic                      out_touched_q;
  logic [ScaleBits-1:0]      out_pos_q;
  logic [CountFieldBits-1:0] out_delta_q;

  logic                 accept;
  logic                 load_out;
  logic [CountBits-1:0] cnt;
  logic [CountBits-1:0] cur_base;
  logic [CountBits-1:0] new_delta;
  logic                 eval_touched;
  logic [ScaleBits-1:0] div_pos;

  div_req_t div_req;
  div_rsp_t div_rsp;

  function automatic logic [PtrBits-1:0] advance(input logic [PtrBits-1:0] p,
                                                  input logic [ElecCntBits-1:0] n);
    logic [ElecCntBits-1:0] lim;
    logic [ElecCntBits-1:0] nxt;
    lim = (n > ElecCntBits'(MaxElectrodes)) ? ElecCntBits'(MaxElectrodes) : n;
    nxt = ElecCntBits'(p) + ElecCntBits'(1);
    return (nxt < lim) ? nxt[PtrBits-1:0] : '0;
  endfunction

  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign cnt        = count_i[CountBits-1:0];
  assign cur_base   = base_q[scan_ptr_q];
  assign new_delta  = (cnt > cur_base) ? (cnt - cur_base) : '0;

  assign eval_touched = (ThrBits'(delta_q[0]) > thr_q) || (ThrBits'(delta_q[1]) > thr_q);

  // both quotients sum to full scale, less one when the division is inexact
  assign div_pos = fs_q - div_rsp.quot - ScaleBits'(div_rsp.rem_nz);

  assign div_req.start = (state_q == S_EVAL) && eval_touched;
  assign div_req.num   = delta_q[0];
  assign div_req.den   = {1'b0, delta_q[0]} + {1'b0, delta_q[1]};
  assign div_req.scale = fs_q;

  tsp_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d   = state_q;
    edelta_d  = edelta_q;
    touched_d = touched_q;
    pos_d     = pos_q;
    load_out  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          edelta_d = (cmd_i == CmdScan) ? new_delta : '0;
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        touched_d = eval_touched;
        if (eval_touched) begin
          state_d = S_DIV;
        end else begin
          pos_d   = '0;
          state_d = S_HOLD;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          pos_d   = div_pos;
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      thr_q       <= ThrBits'(100);
      fs_q        <= ScaleBits'(100);
      ecnt_q      <= ElecCntBits'(2);
      scan_ptr_q  <= '0;
      cal_ptr_q   <= '0;
      for (int i = 0; i < MaxElectrodes; i++) begin
        base_q[i]  <= '0;
        delta_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_THRESHOLD:  thr_q  <= cfg_data_i[ThrBits-1:0];
          CFG_FULL_SCALE: fs_q   <= cfg_data_i[ScaleBits-1:0];
          CFG_ELEC_COUNT: ecnt_q <= cfg_data_i[ElecCntBits-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (cmd_i == CmdCal) begin
          base_q[cal_ptr_q] <= cnt;
          cal_ptr_q         <= advance(cal_ptr_q, ecnt_q);
        end else begin
          delta_q[scan_ptr_q] <= new_delta;
          scan_ptr_q          <= advance(scan_ptr_q, ecnt_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    edelta_q  <= edelta_d;
    touched_q <= touched_d;
    pos_q     <= pos_d;
    if (load_out) begin
      out_chan_q    <= ChanBits'(scan_ptr_q);
      out_touched_q <= touched_q;
      out_pos_q     <= pos_q;
      out_delta_q   <= CountFieldBits'(edelta_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign next_channel_o    = out_chan_q;
  assign touched_o         = out_touched_q;
  assign position_o        = out_pos_q;
  assign electrode_delta_o = out_delta_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EVAL)
    else $error("accepted request did not move to evaluation");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside the wait state");

  a_untouched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !touched_o) |-> position_o == '0)
    else $error("untouched result carries a nonzero position");

endmodule

`default_nettype wire

### verif/touch_slider_position_core_tb.sv
`timescale 1ns / 1ps

module touch_slider_position_core_tb;
  import tsp_pkg::*;

  typedef struct packed {
    logic [ChanBits-1:0]       next_channel;
    logic                      touched;
    logic [ScaleBits-1:0]      position;
    logic [CountFieldBits-1:0] electrode_delta;
  } slider_report_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]     cfg_index_i = '0;
  logic [CfgDataBits-1:0]    cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      cmd_i = CmdCal;
  logic [CountFieldBits-1:0] count_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [ChanBits-1:0]       next_channel_o;
  logic                      touched_o;
  logic [ScaleBits-1:0]      position_o;
  logic [CountFieldBits-1:0] electrode_delta_o;

  // shadow of the slider state and registers
  logic [15:0]          baseline_mem [MaxElectrodes];
  logic [15:0]          delta_mem [MaxElectrodes];
  logic [3:0]           scan_ptr;
  logic [3:0]           cal_ptr;
  logic [15:0]          thr_reg;
  logic [ScaleBits-1:0] scale_reg;
  logic [4:0]           elec_count_reg;

  slider_report_t pending_reports [$];
  int mismatch_count = 0;
  int send_idle_pct = 9;
  int stall_pct = 65;

  touch_slider_position_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .count_i           (count_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .next_channel_o    (next_channel_o),
    .touched_o         (touched_o),
    .position_o        (position_o),
    .electrode_delta_o (electrode_delta_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [3:0] next_pointer(input logic [3:0] p);
    int n;
    n = (elec_count_reg > MaxElectrodes) ? MaxElectrodes : elec_count_reg;
    if (int'(p) + 1 < n) return p + 4'd1;
    return 4'd0;
  endfunction

  function automatic slider_report_t apply_request(input logic cmd,
                                                   input logic [15:0] cnt);
    slider_report_t rep;
    logic [3:0] p;
    longint unsigned d0, d1, s, f, q0, q1;
    rep = '0;
    if (cmd == CmdCal) begin
      baseline_mem[cal_ptr] = cnt;
      cal_ptr = next_pointer(cal_ptr);
    end else begin
      p = scan_ptr;
      rep.electrode_delta = (cnt > baseline_mem[p]) ? cnt - baseline_mem[p] : 16'd0;
      delta_mem[p] = rep.electrode_delta;
      scan_ptr = next_pointer(scan_ptr);
    end
    d0 = delta_mem[0];
    d1 = delta_mem[1];
    rep.touched = (d0 > thr_reg) || (d1 > thr_reg);
    if (rep.touched) begin
      // sum is nonzero here since one delta beats the threshold
      s = d0 + d1;
      f = scale_reg;
      q0 = (d0 * f) / s;
      q1 = (d1 * f) / s;
      rep.position = ScaleBits'(((f - q0) + q1) / 2);
    end
    rep.next_channel = scan_ptr;
    return rep;
  endfunction

  always @(posedge clk_i) begin : check_reports
    slider_report_t want;
    if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: next_channel %0d position %0d",
               next_channel_o, position_o);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        if (next_channel_o !== want.next_channel) begin
          $error("next_channel: expected %0d actual %0d", want.next_channel, next_channel_o);
          mismatch_count++;
        end
        if (touched_o !== want.touched) begin
          $error("touched: expected %0d actual %0d", want.touched, touched_o);
          mismatch_count++;
        end
        if (position_o !== want.position) begin
          $error("position: expected %0d actual %0d", want.position, position_o);
          mismatch_count++;
        end
        if (electrode_delta_o !== want.electrode_delta) begin
          $error("electrode_delta: expected %0d actual %0d",
                 want.electrode_delta, electrode_delta_o);
          mismatch_count++;
        end
      end
    end
  end

  // valid stays high into the next request unless the sender idles first
  task automatic send_request(input logic cmd, input logic [15:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    count_i <= cnt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_reports.push_back(apply_request(cmd, cnt));
  endtask

  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_THRESHOLD:  thr_reg = value;
      CFG_FULL_SCALE: scale_reg = value[ScaleBits-1:0];
      CFG_ELEC_COUNT: elec_count_reg = value[4:0];
      default: ;
    endcase
  endtask

  task automatic test_reset_defaults();
    send_request(CmdScan, 16'h0000);
    send_request(CmdScan, 16'hFFFF);
    send_request(CmdCal, 16'hFFFF);
    send_request(CmdCal, 16'h1234);
    send_request(CmdScan, 16'h0000);
    send_request(CmdScan, 16'h1234 + 16'd101);
    send_request(CmdScan, 16'hFFFF);
    // delta equal to the threshold is not a touch
    send_request(CmdScan, 16'h1234 + 16'd100);
  endtask

  task automatic test_config_extremes();
    wait_until_idle();
    write_reg(CFG_THRESHOLD, 16'd0);
    write_reg(CFG_FULL_SCALE, 16'd4096);
    send_request(CmdCal, 16'h0000);
    send_request(CmdCal, 16'h0000);
    send_request(CmdScan, 16'h0001);
    send_request(CmdScan, 16'hAAAA);
    wait_until_idle();
    write_reg(CFG_FULL_SCALE, 16'd0);
    send_request(CmdScan, 16'h8000);
    wait_until_idle();
    write_reg(CFG_THRESHOLD, 16'hFFFF);
    write_reg(CFG_FULL_SCALE, 16'd1);
    send_request(CmdScan, 16'hFFFF);
  endtask

  task automatic test_pointer_wrap();
    wait_until_idle();
    write_reg(CFG_THRESHOLD, 16'd100);
    write_reg(CFG_FULL_SCALE, 16'd100);
    write_reg(CFG_ELEC_COUNT, 16'd0);
    send_request(CmdCal, 16'h0F0F);
    send_request(CmdScan, 16'h7FFF);
    wait_until_idle();
    write_reg(CFG_ELEC_COUNT, 16'd1);
    send_request(CmdScan, 16'h0100);
    send_request(CmdCal, 16'h00FF);
    wait_until_idle();
    // above the electrode limit behaves as sixteen
    write_reg(CFG_ELEC_COUNT, 16'd31);
    repeat (5) send_request(CmdScan, 16'($urandom));
    wait_until_idle();
    // count lowered below the scan pointer, next advance wraps
    write_reg(CFG_ELEC_COUNT, 16'd3);
    send_request(CmdScan, 16'h4000);
  endtask

  task automatic test_random_traffic(input int send_pct, input int hold_pct,
                                     input int n_items);
    int sent;
    int n_eff;
    int v;
    logic [15:0] b;
    send_idle_pct = send_pct;
    stall_pct = hold_pct;
    sent = 0;
    while (sent < n_items) begin
      wait_until_idle();
      case ($urandom_range(9))
        0: write_reg(CFG_THRESHOLD, 16'd0);
        1: write_reg(CFG_THRESHOLD, 16'hFFFF);
        default: write_reg(CFG_THRESHOLD, 16'($urandom_range(600)));
      endcase
      case ($urandom_range(9))
        0: write_reg(CFG_FULL_SCALE, 16'd1);
        1: write_reg(CFG_FULL_SCALE, 16'd4096);
        2: write_reg(CFG_FULL_SCALE, 16'd0);
        default: write_reg(CFG_FULL_SCALE, 16'($urandom_range(1, 4096)));
      endcase
      case ($urandom_range(9))
        0: write_reg(CFG_ELEC_COUNT, 16'd0);
        1: write_reg(CFG_ELEC_COUNT, 16'd1);
        2: write_reg(CFG_ELEC_COUNT, 16'($urandom_range(17, 31)));
        3: write_reg(CFG_ELEC_COUNT, 16'd16);
        default: write_reg(CFG_ELEC_COUNT, 16'($urandom_range(2, 8)));
      endcase
      // calibration sweep over every active electrode
      n_eff = (elec_count_reg > MaxElectrodes) ? MaxElectrodes :
              (elec_count_reg == 0) ? 1 : elec_count_reg;
      for (int i = 0; i < n_eff; i++) begin
        case ($urandom_range(9))
          0: send_request(CmdCal, 16'h0000);
          1: send_request(CmdCal, 16'hFFFF);
          2: send_request(CmdCal, 16'($urandom));
          default: send_request(CmdCal, 16'($urandom_range(500, 50000)));
        endcase
        sent++;
      end
      repeat ($urandom_range(20, 60)) begin
        if ($urandom_range(19) == 0) begin
          // stray calibration request mid scan
          send_request(CmdCal, 16'($urandom));
        end else begin
          b = baseline_mem[scan_ptr];
          case ($urandom_range(9))
            0: v = int'($urandom_range(0, 65535));
            1: v = int'(b) - int'($urandom_range(0, 300));
            default: v = int'(b) + int'($urandom_range(0, 1500));
          endcase
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
          send_request(CmdScan, 16'(v));
        end
        sent++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MaxElectrodes; i++) begin
      baseline_mem[i] = '0;
      delta_mem[i] = '0;
    end
    scan_ptr = '0;
    cal_ptr = '0;
    thr_reg = 16'd100;
    scale_reg = 13'd100;
    elec_count_reg = 5'd2;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_config_extremes();
    test_pointer_wrap();
    test_random_traffic(9, 65, 530);
    test_random_traffic(65, 9, 530);
    test_random_traffic(0, 0, 530);

    wait_until_idle();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

### touch_slider_position_core.f
rtl/tsp_pkg.sv
rtl/tsp_muldiv.sv
rtl/touch_slider_position_core.sv
verif/touch_slider_position_core_tb.sv
